/* rtl/core/e2r_pkg.sv */
// shared constants, types and functions for the euler to rotation matrix block
`timescale 1ns / 1ps
package e2r_pkg;

  localparam int AngleBitsDef  = 16;
  localparam int EntryBitsDef  = 16;
  localparam int TrigStagesDef = 16;

  // internal word: Q30 with sign and headroom
  localparam int QW = 34;

  localparam logic signed [QW-1:0] OneQ30    = 34'sd1073741824;
  localparam logic signed [QW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [QW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [QW-1:0] InvGainQ30 = 34'sd652032874;

  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
    logic neg;
  } cordic_t;

  typedef struct packed {
    q_t s;
    q_t c;
  } trig_t;

  function automatic q_t atan_q30(input logic [4:0] i);
    q_t r;
    case (i)
      5'd0:  r = 34'sh03243F6A8;
      5'd1:  r = 34'sh01DAC6705;
      5'd2:  r = 34'sh00FADBAFC;
      5'd3:  r = 34'sh007F56EA6;
      5'd4:  r = 34'sh003FEAB76;
      5'd5:  r = 34'sh001FFD55B;
      5'd6:  r = 34'sh000FFFAAA;
      5'd7:  r = 34'sh0007FFF55;
      5'd8:  r = 34'sh0003FFFEA;
      5'd9:  r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;
      5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;
      5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;
      5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;
      5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;
      5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;
      5'd23: r = 34'sh00000007F;
      5'd24: r = 34'sh00000003F;
      5'd25: r = 34'sh00000001F;
      5'd26: r = 34'sh00000000F;
      5'd27: r = 34'sh000000007;
      5'd28: r = 34'sh000000003;
      5'd29: r = 34'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic q_t clamp_one(input q_t v);
    q_t r;
    if (v > OneQ30) r = OneQ30;
    else if (v < -OneQ30) r = -OneQ30;
    else r = v;
    return r;
  endfunction

  // rounded Q30 product, inputs within plus or minus 2^31
  function automatic q_t mul_q30(input q_t a, input q_t b);
    logic signed [2*QW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return q_t'(p >>> 30);
  endfunction

endpackage

/* rtl/core/e2r_cordic.sv */
// pipelined rotation-mode cordic giving sine and cosine of one angle
`timescale 1ns / 1ps
module e2r_cordic #(
  parameter int ANGLE_BITS  = e2r_pkg::AngleBitsDef,
  parameter int TRIG_STAGES = e2r_pkg::TrigStagesDef
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [ANGLE_BITS-1:0] angle_i,
  output e2r_pkg::trig_t               trig_o
);
  e2r_pkg::cordic_t st_q [TRIG_STAGES+1];
  e2r_pkg::trig_t   trig_q;
  e2r_pkg::cordic_t st0_d;
  e2r_pkg::q_t      a;

  always_comb begin
    a = e2r_pkg::q_t'(angle_i) <<< (33 - ANGLE_BITS);
    st0_d.x = e2r_pkg::InvGainQ30;
    st0_d.y = '0;
    st0_d.neg = 1'b0;
    st0_d.z = a;
    if (a > e2r_pkg::HalfPiQ30) begin
      st0_d.z = a - e2r_pkg::PiQ30;
      st0_d.neg = 1'b1;
    end else if (a < -e2r_pkg::HalfPiQ30) begin
      st0_d.z = a + e2r_pkg::PiQ30;
      st0_d.neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q[0] <= st0_d;
  end

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
    e2r_pkg::cordic_t nx_d;
    always_comb begin
      nx_d = st_q[i];
      if (!st_q[i].z[e2r_pkg::QW-1]) begin
        nx_d.x = st_q[i].x - (st_q[i].y >>> i);
        nx_d.y = st_q[i].y + (st_q[i].x >>> i);
        nx_d.z = st_q[i].z - e2r_pkg::atan_q30(5'(i));
      end else begin
        nx_d.x = st_q[i].x + (st_q[i].y >>> i);
        nx_d.y = st_q[i].y - (st_q[i].x >>> i);
        nx_d.z = st_q[i].z + e2r_pkg::atan_q30(5'(i));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[i+1] <= nx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q.c <= e2r_pkg::clamp_one(st_q[TRIG_STAGES].neg ? -st_q[TRIG_STAGES].x
                                                           : st_q[TRIG_STAGES].x);
      trig_q.s <= e2r_pkg::clamp_one(st_q[TRIG_STAGES].neg ? -st_q[TRIG_STAGES].y
                                                           : st_q[TRIG_STAGES].y);
    end
  end

  assign trig_o = trig_q;
endmodule

/* rtl/core/e2r_matrix.sv */
// product pipeline forming the nine matrix entries: first products, second products, rounding, output
`timescale 1ns / 1ps
module e2r_matrix #(
  parameter int ENTRY_BITS = e2r_pkg::EntryBitsDef
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  e2r_pkg::trig_t               tx_i,
  input  e2r_pkg::trig_t               ty_i,
  input  e2r_pkg::trig_t               tz_i,
  output logic signed [ENTRY_BITS-1:0] ent_o [9]
);
  localparam int Sh = 32 - ENTRY_BITS;
  localparam logic signed [e2r_pkg::QW-1:0] Lim = e2r_pkg::QW'(1) <<< (ENTRY_BITS - 2);

  // stage a: first products
  e2r_pkg::q_t czsy_q, szsy_q, czcy_q, szcy_q, szcx_q, szsx_q, czcx_q, czsx_q;
  e2r_pkg::q_t cysx_q, cycx_q, nsy_q, sx_q, cx_q;
  // stage b: second products
  e2r_pkg::q_t p_q [9];
  e2r_pkg::q_t e_q [9];
  logic signed [ENTRY_BITS-1:0] o_q [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      czsy_q <= e2r_pkg::mul_q30(tz_i.c, ty_i.s);
      szsy_q <= e2r_pkg::mul_q30(tz_i.s, ty_i.s);
      czcy_q <= e2r_pkg::mul_q30(tz_i.c, ty_i.c);
      szcy_q <= e2r_pkg::mul_q30(tz_i.s, ty_i.c);
      szcx_q <= e2r_pkg::mul_q30(tz_i.s, tx_i.c);
      szsx_q <= e2r_pkg::mul_q30(tz_i.s, tx_i.s);
      czcx_q <= e2r_pkg::mul_q30(tz_i.c, tx_i.c);
      czsx_q <= e2r_pkg::mul_q30(tz_i.c, tx_i.s);
      cysx_q <= e2r_pkg::mul_q30(ty_i.c, tx_i.s);
      cycx_q <= e2r_pkg::mul_q30(ty_i.c, tx_i.c);
      nsy_q  <= -ty_i.s;
      sx_q   <= tx_i.s;
      cx_q   <= tx_i.c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= czcy_q;
      p_q[1] <= e2r_pkg::mul_q30(czsy_q, sx_q) - szcx_q;
      p_q[2] <= e2r_pkg::mul_q30(czsy_q, cx_q) + szsx_q;
      p_q[3] <= szcy_q;
      p_q[4] <= e2r_pkg::mul_q30(szsy_q, sx_q) + czcx_q;
      p_q[5] <= e2r_pkg::mul_q30(szsy_q, cx_q) - czsx_q;
      p_q[6] <= nsy_q;
      p_q[7] <= cysx_q;
      p_q[8] <= cycx_q;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_out
    e2r_pkg::q_t r_d;
    always_comb begin
      if (Sh > 0) r_d = (p_q[k] + (e2r_pkg::QW'(1) <<< (Sh > 0 ? Sh - 1 : 0))) >>> Sh;
      else r_d = p_q[k];
      if (r_d > Lim) r_d = Lim;
      else if (r_d < -Lim) r_d = -Lim;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) e_q[k] <= r_d;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) o_q[k] <= e_q[k][ENTRY_BITS-1:0];
    end
    assign ent_o[k] = o_q[k];
  end
endmodule

/* rtl/core/euler_to_rotation_matrix.sv */
// euler zyx angles to rotation matrix, pipelined cordic and product stages
//
// channel  direction  signals
// in       input      in_valid_i, in_ready_o, angle_x_i, angle_y_i, angle_z_i
// out      output     out_valid_o, out_ready_i, r00_o .. r22_o
//
// one transaction per cycle sustained while out_ready_i is high
// the cordic stage chain and the product stages set the pipe depth, every stage holds one item
// the whole pipe advances when the last stage is empty or being taken
// reset clears only the stage valid bits
`timescale 1ns / 1ps
module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS  = e2r_pkg::AngleBitsDef,
  parameter int ENTRY_BITS  = e2r_pkg::EntryBitsDef,
  parameter int TRIG_STAGES = e2r_pkg::TrigStagesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [ANGLE_BITS-1:0] angle_x_i,
  input  logic signed [ANGLE_BITS-1:0] angle_y_i,
  input  logic signed [ANGLE_BITS-1:0] angle_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [ENTRY_BITS-1:0] r00_o,
  output logic signed [ENTRY_BITS-1:0] r01_o,
  output logic signed [ENTRY_BITS-1:0] r02_o,
  output logic signed [ENTRY_BITS-1:0] r10_o,
  output logic signed [ENTRY_BITS-1:0] r11_o,
  output logic signed [ENTRY_BITS-1:0] r12_o,
  output logic signed [ENTRY_BITS-1:0] r20_o,
  output logic signed [ENTRY_BITS-1:0] r21_o,
  output logic signed [ENTRY_BITS-1:0] r22_o
);
  localparam int Lat = TRIG_STAGES + 6;

  logic [Lat-1:0] vld_q;
  logic           en;
  e2r_pkg::trig_t tx, ty, tz;
  logic signed [ENTRY_BITS-1:0] ent [9];

  assign en = !vld_q[Lat-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_cx (
    .clk_i, .en_i(en), .angle_i(angle_x_i), .trig_o(tx));
  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_cy (
    .clk_i, .en_i(en), .angle_i(angle_y_i), .trig_o(ty));
  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_cz (
    .clk_i, .en_i(en), .angle_i(angle_z_i), .trig_o(tz));

  e2r_matrix #(.ENTRY_BITS(ENTRY_BITS)) u_mat (
    .clk_i, .en_i(en), .tx_i(tx), .ty_i(ty), .tz_i(tz), .ent_o(ent));

  assign r00_o = ent[0];
  assign r01_o = ent[1];
  assign r02_o = ent[2];
  assign r10_o = ent[3];
  assign r11_o = ent[4];
  assign r12_o = ent[5];
  assign r20_o = ent[6];
  assign r21_o = ent[7];
  assign r22_o = ent[8];

  // a stalled result holds its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(r00_o) && $stable(r22_o))
    else $error("stalled result changed");
  // ready only drops while the last stage holds a result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("ready low without pending result");
  // bottom-left entry r20 of a rotation is never below minus one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> r20_o >= -(1 <<< (ENTRY_BITS - 2)))
    else $error("entry out of range");
endmodule

/* test/euler_to_rotation_matrix_tb.sv */
// testbench for the euler to rotation matrix block with a bit-exact matrix predictor
`timescale 1ns / 1ps
module euler_to_rotation_matrix_tb;

  localparam int NumRandom = 1800;
  localparam int Latency = e2r_pkg::TrigStagesDef + 6;
  localparam longint CycleLimit = 400000;

  typedef logic signed [15:0] angle_t;
  typedef logic signed [15:0] entry_t;

  typedef struct {
    angle_t ax;
    angle_t ay;
    angle_t az;
  } angles_t;

  typedef struct {
    entry_t e [9];
  } matrix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  angle_t angle_x_i = '0, angle_y_i = '0, angle_z_i = '0;
  logic in_ready_o, out_valid_o;
  entry_t r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  angles_t pending_angles[$];
  matrix_t expected_matrices[$];
  int errors = 0;
  int matrices_seen = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_cycles = 0;
  bit sender_paused = 1'b0;
  bit stim_done = 1'b0;
  longint cycles = 0;

  always #1 clk_i = ~clk_i;

  euler_to_rotation_matrix u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .angle_x_i, .angle_y_i, .angle_z_i,
    .out_valid_o, .out_ready_i, .r00_o, .r01_o, .r02_o, .r10_o, .r11_o, .r12_o,
    .r20_o, .r21_o, .r22_o
  );

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_mul(longint a, longint b);
    return floor_shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint limit_one(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void sine_cosine(angle_t a, output longint sn, output longint cs);
    longint z, x, y, nx;
    longint atan_i;
    bit flip;
    z = longint'(a) <<< 17;
    x = longint'(e2r_pkg::InvGainQ30);
    y = 0;
    flip = 1'b0;
    if (z > longint'(e2r_pkg::HalfPiQ30)) begin
      z -= longint'(e2r_pkg::PiQ30);
      flip = 1'b1;
    end else if (z < -longint'(e2r_pkg::HalfPiQ30)) begin
      z += longint'(e2r_pkg::PiQ30);
      flip = 1'b1;
    end
    for (int i = 0; i < e2r_pkg::TrigStagesDef; i++) begin
      // arctangent table in Q30, truncated
      case (i)
        0: atan_i = 64'h3243F6A8; 1: atan_i = 64'h1DAC6705; 2: atan_i = 64'h0FADBAFC;
        3: atan_i = 64'h07F56EA6; 4: atan_i = 64'h03FEAB76; 5: atan_i = 64'h01FFD55B;
        6: atan_i = 64'h00FFFAAA; 7: atan_i = 64'h007FFF55; 8: atan_i = 64'h003FFFEA;
        9: atan_i = 64'h001FFFFD; 10: atan_i = 64'h000FFFFF; 11: atan_i = 64'h0007FFFF;
        12: atan_i = 64'h0003FFFF; 13: atan_i = 64'h0001FFFF; 14: atan_i = 64'h0000FFFF;
        default: atan_i = 64'h00007FFF;
      endcase
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z -= atan_i;
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z += atan_i;
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = limit_one(x, 64'sd1 <<< 30);
    sn = limit_one(y, 64'sd1 <<< 30);
  endfunction

  function automatic entry_t to_entry(longint v);
    return entry_t'(limit_one(floor_shr(v + (64'sd1 <<< 15), 16), 16384));
  endfunction

  function automatic matrix_t rotation_of(angles_t a);
    matrix_t m;
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    sine_cosine(a.ax, sx, cx);
    sine_cosine(a.ay, sy, cy);
    sine_cosine(a.az, sz, cz);
    czsy = round_mul(cz, sy);
    szsy = round_mul(sz, sy);
    m.e[0] = to_entry(round_mul(cz, cy));
    m.e[1] = to_entry(round_mul(czsy, sx) - round_mul(sz, cx));
    m.e[2] = to_entry(round_mul(czsy, cx) + round_mul(sz, sx));
    m.e[3] = to_entry(round_mul(sz, cy));
    m.e[4] = to_entry(round_mul(szsy, sx) + round_mul(cz, cx));
    m.e[5] = to_entry(round_mul(szsy, cx) - round_mul(cz, sx));
    m.e[6] = to_entry(-sy);
    m.e[7] = to_entry(round_mul(cy, sx));
    m.e[8] = to_entry(round_mul(cy, cx));
    return m;
  endfunction

  function automatic void queue_angles(int x, int y, int z);
    angles_t a;
    a.ax = angle_t'(x);
    a.ay = angle_t'(y);
    a.az = angle_t'(z);
    pending_angles.push_back(a);
  endfunction

  function automatic int random_angle();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return $urandom_range(0, 1) ? 12868 : -12868;   // near plus or minus pi/2
      2: return $urandom_range(0, 1) ? 25736 : -25736;   // near plus or minus pi
      3: return int'($urandom_range(0, 40)) - 20;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        angles_t acc;
        acc.ax = angle_x_i;
        acc.ay = angle_y_i;
        acc.az = angle_z_i;
        expected_matrices.push_back(rotation_of(acc));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_angles.size() > 0 && !sender_paused &&
            $urandom_range(0, 99) >= sender_idle_pct) begin
          angles_t nxt;
          nxt = pending_angles.pop_front();
          in_valid_i <= 1'b1;
          angle_x_i <= nxt.ax;
          angle_y_i <= nxt.ay;
          angle_z_i <= nxt.az;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        entry_t got [9];
        matrix_t want;
        got = '{r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o};
        if (expected_matrices.size() == 0) begin
          $error("matrix transaction with nothing expected");
          errors++;
        end else begin
          want = expected_matrices.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (got[k] !== want.e[k]) begin
              $error("r%0d%0d: expected %0d, actual %0d", k / 3, k % 3, want.e[k], got[k]);
              errors++;
            end
          end
        end
        matrices_seen++;
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  task automatic drain();
    while (pending_angles.size() > 0 || in_valid_i || expected_matrices.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zeros, extremes, quarter and half turns
    queue_angles(0, 0, 0);
    queue_angles(32767, 32767, 32767);
    queue_angles(-32768, -32768, -32768);
    queue_angles(12868, 0, 0);
    queue_angles(0, 12868, 0);
    queue_angles(0, 0, 12868);
    queue_angles(-12868, -12868, -12868);
    queue_angles(12867, 12869, -12869);
    queue_angles(25736, 0, 0);
    queue_angles(0, -25736, 25736);
    queue_angles(25735, 25737, -25737);
    queue_angles(-1, 1, -1);
    queue_angles(21845, -10923, 5461);
    queue_angles(32767, -32768, 0);
    drain();

    // long receiver hold while the sender keeps offering
    hold_cycles = 200;
    for (int n = 0; n < 100; n++) queue_angles(random_angle(), random_angle(), random_angle());
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 48 : 0;
      receiver_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 36 : 0;
      for (int n = 0; n < NumRandom / 3; n++) begin
        queue_angles(random_angle(), random_angle(), random_angle());
        // once per phase the sender waits for the pipe to empty
        if (n == 150) begin
          while (pending_angles.size() > 0 || in_valid_i) @(posedge clk_i);
          sender_paused = 1'b1;
          drain();
          sender_paused = 1'b0;
        end
      end
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (Latency + 10) @(posedge clk_i);
    $display("covered %0d angle triples: extremes, quarter and half turns, random angles",
             matrices_seen);
    $display("with random idling on both sides, a long output stall and an input pause");
    if (errors == 0 && expected_matrices.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("timeout at cycle %0d", cycles);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
